// File: hdl/fbhs_pkg.sv
// ----------------------------------------------------------------------------
// Bitstream header skipper package
// Shared types and constants for the bitstream file header skipper.
// ----------------------------------------------------------------------------
package fbhs_pkg;

   // Widths of the request and response fields.
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned OFFSET_W = 23;

   // File layout constants.
   localparam logic [OFFSET_W-1:0] FIELD_START_INIT = 23'd13;
   localparam logic [OFFSET_W-1:0] MIN_HEADER_BYTES = 23'd20;
   localparam logic [OFFSET_W-1:0] FIELD_HDR_BYTES  = 23'd3;
   localparam logic [OFFSET_W-1:0] TAG_E_SKIP       = 23'd5;
   localparam logic [OFFSET_W-1:0] SIG_LAST_POS     = 23'd3;
   localparam logic [OFFSET_W-1:0] SIG_LEN          = 23'd4;

   // Signature at the start of a file with a header.
   localparam logic [BYTE_W-1:0] SIG_BYTES [4] = '{8'h00, 8'h09, 8'h0F, 8'hF0};

   // Field tags.
   localparam logic [BYTE_W-1:0] TAG_A = 8'h61;
   localparam logic [BYTE_W-1:0] TAG_D = 8'h64;
   localparam logic [BYTE_W-1:0] TAG_E = 8'h65;

   // Parse phases.
   typedef enum logic [2:0] {
      PHASE_SIG,
      PHASE_TAG,
      PHASE_LENHI,
      PHASE_LENLO,
      PHASE_DONE
   } phase_type;

   // One request item.
   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      logic              last_byte;
   } item_type;

   // One response item.
   typedef struct packed {
      logic [OFFSET_W-1:0] payload_offset;
      logic                header_found;
   } result_type;

   // Hand-off from the input stage to the parser.
   typedef struct packed {
      logic     fire;
      item_type item;
   } stage_type;

endpackage

// File: hdl/fbhs_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one file byte and its final-byte flag.
// ----------------------------------------------------------------------------
interface fbhs_req_if;
   logic                          valid;
   logic                          ready;
   logic [fbhs_pkg::BYTE_W-1:0]   byte_value;
   logic                          last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

// File: hdl/fbhs_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries the payload offset and header flag.
// ----------------------------------------------------------------------------
interface fbhs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fbhs_pkg::OFFSET_W-1:0] payload_offset;
   logic                          header_found;

   modport source (output valid, output payload_offset, output header_found, input ready);
   modport sink   (input valid, input payload_offset, input header_found, output ready);
endinterface

// File: hdl/fbhs_in_stage.sv
// ----------------------------------------------------------------------------
// Input stage
// Registers each request and passes it to the parser when the output allows.
// ----------------------------------------------------------------------------
module fbhs_in_stage (
   input  logic                clock,
   input  logic                reset,
   fbhs_req_if.sink            req_if,
   input  logic                out_blocked,
   output fbhs_pkg::stage_type stage
);
   import fbhs_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     advance;

   // A final byte waits until the output register can take its result.
   assign advance      = valid_ff && (!item_ff.last_byte || !out_blocked);
   assign req_if.ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_if.ready) begin
         valid_in           = req_if.valid;
         item_in.byte_value = req_if.byte_value;
         item_in.last_byte  = req_if.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign stage.fire = advance;
   assign stage.item = item_ff;

endmodule

// File: hdl/fbhs_parser.sv
// ----------------------------------------------------------------------------
// Header parser
// Tracks the file position and tag fields and forms the result on the final
// byte.
// ----------------------------------------------------------------------------
module fbhs_parser #(
   parameter int unsigned MAX_FILE_BYTES = 4194304
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fbhs_pkg::stage_type  stage,
   output fbhs_pkg::result_type result
);
   import fbhs_pkg::*;

   localparam logic [OFFSET_W-1:0] MAX_POS = OFFSET_W'(MAX_FILE_BYTES);

   logic [OFFSET_W-1:0] byte_position_ff, byte_position_in;
   phase_type           parse_phase_ff, parse_phase_in;
   logic [OFFSET_W-1:0] field_start_ff, field_start_in;
   logic [BYTE_W-1:0]   length_high_ff, length_high_in;
   logic                signature_ok_ff, signature_ok_in;
   logic                offset_decided_ff, offset_decided_in;
   logic [OFFSET_W-1:0] decided_offset_ff, decided_offset_in;

   logic [BYTE_W-1:0]   b;
   logic [OFFSET_W-1:0] pos;
   logic [OFFSET_W:0]   tail_end;
   logic                header_ok;

   assign b   = stage.item.byte_value;
   assign pos = byte_position_ff;

   // End of the three-byte field header at the current field start.
   assign tail_end = {1'b0, field_start_ff} + {1'b0, FIELD_HDR_BYTES};

   // Consume one byte, then form the result and restart on a final byte.
   always_comb begin
      byte_position_in  = byte_position_ff;
      parse_phase_in    = parse_phase_ff;
      field_start_in    = field_start_ff;
      length_high_in    = length_high_ff;
      signature_ok_in   = signature_ok_ff;
      offset_decided_in = offset_decided_ff;
      decided_offset_in = decided_offset_ff;
      header_ok         = 1'b0;
      result            = '0;

      if (pos < MAX_POS) begin
         if (pos < SIG_LEN) begin
            if (b != SIG_BYTES[pos[1:0]]) begin
               signature_ok_in = 1'b0;
            end
            if (pos == SIG_LAST_POS) begin
               parse_phase_in = PHASE_TAG;
            end
         end
         if (parse_phase_in == PHASE_TAG && pos == field_start_ff) begin
            if (b == TAG_E) begin
               decided_offset_in = field_start_ff + TAG_E_SKIP;
               offset_decided_in = 1'b1;
               parse_phase_in    = PHASE_DONE;
            end else if (b < TAG_A || b > TAG_D) begin
               decided_offset_in = field_start_ff;
               offset_decided_in = 1'b1;
               parse_phase_in    = PHASE_DONE;
            end else begin
               parse_phase_in = PHASE_LENHI;
            end
         end else if (parse_phase_in == PHASE_LENHI) begin
            length_high_in = b;
            parse_phase_in = PHASE_LENLO;
         end else if (parse_phase_in == PHASE_LENLO) begin
            field_start_in = field_start_ff + FIELD_HDR_BYTES +
                             OFFSET_W'({length_high_ff, b});
            parse_phase_in = PHASE_TAG;
         end
         byte_position_in = pos + 23'd1;
      end

      // Result. Once an offset is decided the field start no longer moves.
      header_ok           = (byte_position_in >= MIN_HEADER_BYTES) && signature_ok_in;
      result.header_found = header_ok;
      if (header_ok) begin
         if (offset_decided_in && ({1'b0, byte_position_in} >= tail_end)) begin
            result.payload_offset = decided_offset_in;
         end else begin
            result.payload_offset = field_start_in;
         end
      end

      if (stage.item.last_byte) begin
         byte_position_in  = '0;
         parse_phase_in    = PHASE_SIG;
         field_start_in    = FIELD_START_INIT;
         length_high_in    = '0;
         signature_ok_in   = 1'b1;
         offset_decided_in = 1'b0;
         decided_offset_in = '0;
      end
   end

   // Parser state advances only when a byte moves in from the input stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff  <= '0;
         parse_phase_ff    <= PHASE_SIG;
         field_start_ff    <= FIELD_START_INIT;
         length_high_ff    <= '0;
         signature_ok_ff   <= 1'b1;
         offset_decided_ff <= 1'b0;
         decided_offset_ff <= '0;
      end else if (stage.fire) begin
         byte_position_ff  <= byte_position_in;
         parse_phase_ff    <= parse_phase_in;
         field_start_ff    <= field_start_in;
         length_high_ff    <= length_high_in;
         signature_ok_ff   <= signature_ok_in;
         offset_decided_ff <= offset_decided_in;
         decided_offset_ff <= decided_offset_in;
      end
   end

endmodule

// File: hdl/fbhs_out_reg.sv
// ----------------------------------------------------------------------------
// Output register
// Holds one response until the response channel takes it.
// ----------------------------------------------------------------------------
module fbhs_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  fbhs_pkg::stage_type  stage,
   input  fbhs_pkg::result_type result,
   output logic                 out_blocked,
   fbhs_rsp_if.source           rsp_if
);
   import fbhs_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;
   logic       load;

   // A response is loaded when a final byte leaves the input stage.
   assign load        = stage.fire && stage.item.last_byte;
   assign out_blocked = valid_ff && !rsp_if.ready;

   always_comb begin
      valid_in  = valid_ff && !rsp_if.ready;
      result_in = result_ff;
      if (load) begin
         valid_in  = 1'b1;
         result_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_if.valid          = valid_ff;
   assign rsp_if.payload_offset = result_ff.payload_offset;
   assign rsp_if.header_found   = result_ff.header_found;

endmodule

// File: hdl/fpga_bitfile_header_skipper_top.sv
// The final byte is held in the input register and its response is loaded
// into the output register. Throughput: one byte per cycle, except while a final
// byte stalls; the parser result is combinational between the two registers.
// A final byte stalls only while the previous response is held and not taken.
// Reset (synchronous, active high) empties both registers and restarts the
// parser at the start of a new file.
// ----------------------------------------------------------------------------
// Bitstream file header skipper
// Finds the payload start offset of a configuration bitstream file.
// ----------------------------------------------------------------------------
module fpga_bitfile_header_skipper_top #(
   parameter int unsigned MAX_FILE_BYTES = 4194304
) (
   input  logic       clock,
   input  logic       reset,
   fbhs_req_if.sink   req_if,
   fbhs_rsp_if.source rsp_if
);
   import fbhs_pkg::*;

   stage_type  stage;
   result_type result;
   logic       out_blocked;

   // Input register.
   fbhs_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .out_blocked (out_blocked),
      .stage       (stage)
   );

   // Parser state and result logic.
   fbhs_parser #(
      .MAX_FILE_BYTES (MAX_FILE_BYTES)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .stage  (stage),
      .result (result)
   );

   // Response register.
   fbhs_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .stage       (stage),
      .result      (result),
      .out_blocked (out_blocked),
      .rsp_if      (rsp_if)
   );

endmodule

// File: verif/fpga_bitfile_header_skipper_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitstream file header skipper testbench
// Streams whole files into the skipper, one byte per request, and predicts the
// payload offset and header flag of every file. Each response is checked
// against the oldest prediction. Directed files cover raw binaries, every tag
// kind, short tails, oversized lengths and overlong files; random files follow
// with random gaps on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module fpga_bitfile_header_skipper_top_tb;
   import fbhs_pkg::*;

   // A small file size cap keeps overlong files cheap to simulate.
   localparam int unsigned FILE_BYTE_CAP = 64;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned RANDOM_BYTES  = 580;

   logic clock;
   logic reset;

   fbhs_req_if req_if ();
   fbhs_rsp_if rsp_if ();

   fpga_bitfile_header_skipper_top #(
      .MAX_FILE_BYTES(FILE_BYTE_CAP)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Predicted parser state.
   logic [OFFSET_W-1:0] pos_q;
   logic [OFFSET_W-1:0] field_q;
   logic [OFFSET_W-1:0] decided_q;
   logic [BYTE_W-1:0]   len_hi_q;
   phase_type           phase_q;
   logic                sig_ok_q;
   logic                decided_set_q;

   result_type  expected_offsets[$];
   logic [7:0]  file_q[$];

   int  fail_count      = 0;
   int  bytes_accepted  = 0;
   int  cycle_count     = 0;
   bit  no_idle         = 0;
   bit  hold_off_req    = 0;

   // Clock generation.
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // The run ends here if the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Return the predicted parser to the start of a new file.
   task automatic clear_file_state();
      pos_q         = '0;
      phase_q       = PHASE_SIG;
      field_q       = FIELD_START_INIT;
      len_hi_q      = '0;
      sig_ok_q      = 1'b1;
      decided_set_q = 1'b0;
      decided_q     = '0;
   endtask

   // Advance the predicted parser by one accepted byte and, on the final
   // byte, queue the expected payload offset.
   task automatic track_file_byte(input logic [7:0] b, input logic last);
      result_type  res;
      logic [31:0] total;
      if (pos_q < FILE_BYTE_CAP) begin
         if (pos_q < SIG_LEN) begin
            if (b != SIG_BYTES[pos_q[1:0]]) sig_ok_q = 1'b0;
            if (pos_q == SIG_LAST_POS) phase_q = PHASE_TAG;
         end
         if (phase_q == PHASE_TAG && pos_q == field_q) begin
            if (b == TAG_E) begin
               decided_q     = field_q + TAG_E_SKIP;
               decided_set_q = 1'b1;
               phase_q       = PHASE_DONE;
            end else if (b < TAG_A || b > TAG_D) begin
               decided_q     = field_q;
               decided_set_q = 1'b1;
               phase_q       = PHASE_DONE;
            end else begin
               phase_q = PHASE_LENHI;
            end
         end else if (phase_q == PHASE_LENHI) begin
            len_hi_q = b;
            phase_q  = PHASE_LENLO;
         end else if (phase_q == PHASE_LENLO) begin
            field_q = field_q + FIELD_HDR_BYTES + OFFSET_W'({len_hi_q, b});
            phase_q = PHASE_TAG;
         end
         pos_q = pos_q + 23'd1;
      end
      if (last) begin
         total = {9'd0, pos_q};
         if (total < MIN_HEADER_BYTES || !sig_ok_q) begin
            res.payload_offset = '0;
            res.header_found   = 1'b0;
         end else begin
            res.header_found = 1'b1;
            // A tag too close to the end of the file does not count.
            if (decided_set_q && total >= {9'd0, field_q} + {9'd0, FIELD_HDR_BYTES})
               res.payload_offset = decided_q;
            else
               res.payload_offset = field_q;
         end
         expected_offsets.push_back(res);
         clear_file_state();
      end
   endtask

   // Offer one byte after a random gap and wait until the request is taken.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.byte_value <= b;
      req_if.last_byte  <= last;
      do @(posedge clock); while (!req_if.ready);
      track_file_byte(b, last);
      bytes_accepted++;
      @(negedge clock);
   endtask

   // Send the file buffer, flagging its final byte.
   task automatic send_file();
      for (int i = 0; i < file_q.size(); i++)
         send_byte(file_q[i], i == file_q.size() - 1);
   endtask

   // Begin a file with the signature, optionally corrupted, and random bytes
   // up to the first field.
   task automatic start_file(input bit good_sig);
      logic [7:0] rnd;
      int         idx;
      file_q.delete();
      for (int i = 0; i < SIG_LEN; i++) file_q.push_back(SIG_BYTES[i]);
      if (!good_sig) begin
         idx         = $urandom_range(0, 3);
         rnd         = 8'($urandom_range(1, 255));
         file_q[idx] = file_q[idx] ^ rnd;
      end
      while (file_q.size() < FIELD_START_INIT) begin
         rnd = 8'($urandom);
         file_q.push_back(rnd);
      end
   endtask

   // Append a tag, its big-endian length and some random content.
   task automatic add_field(input logic [7:0] tag, input logic [15:0] len, input int n);
      logic [7:0] rnd;
      file_q.push_back(tag);
      file_q.push_back(len[15:8]);
      file_q.push_back(len[7:0]);
      repeat (n) begin
         rnd = 8'($urandom);
         file_q.push_back(rnd);
      end
   endtask

   task automatic add_random_bytes(input int n);
      logic [7:0] rnd;
      repeat (n) begin
         rnd = 8'($urandom);
         file_q.push_back(rnd);
      end
   endtask

   // Build and send one random file: mostly well-formed headers with random
   // content, plus raw binaries, broken signatures, truncation and padding.
   task automatic send_random_file();
      int         kind;
      int         keep;
      logic [7:0] tag;
      logic [15:0] len;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         file_q.delete();
         add_random_bytes($urandom_range(1, 40));
      end else begin
         start_file(kind != 1);
         repeat ($urandom_range(0, 4)) begin
            tag = TAG_A + 8'($urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0) begin
               len = 16'($urandom_range(0, 65535));
               add_field(tag, len, $urandom_range(0, 4));
            end else begin
               len = 16'($urandom_range(0, 6));
               add_field(tag, len, int'(len));
            end
         end
         case ($urandom_range(0, 3))
            0: begin
               file_q.push_back(TAG_E);
               add_random_bytes(4);
            end
            1: begin
               do tag = 8'($urandom_range(0, 255)); while (tag >= TAG_A && tag <= TAG_E);
               file_q.push_back(tag);
            end
            2: begin
               file_q.push_back(TAG_E);
            end
            default: ;
         endcase
         add_random_bytes($urandom_range(0, 8));
      end
      // Cut the file short somewhere.
      if ($urandom_range(0, 3) == 0) begin
         keep = $urandom_range(1, file_q.size());
         while (file_q.size() > keep) void'(file_q.pop_back());
      end
      // Run past the file size cap now and then.
      if ($urandom_range(0, 11) == 0)
         add_random_bytes(FILE_BYTE_CAP + $urandom_range(1, 20) - file_q.size());
      send_file();
   endtask

   // Files too short or without the signature are raw binaries.
   task automatic test_raw_files();
      file_q.delete();
      file_q.push_back(8'hFF);
      send_file();
      start_file(1'b1);
      add_random_bytes(int'(MIN_HEADER_BYTES) - 1 - int'(FIELD_START_INIT));
      send_file();
      start_file(1'b0);
      add_random_bytes(int'(MIN_HEADER_BYTES) - int'(FIELD_START_INIT));
      send_file();
   endtask

   // Walk every skipped tag, then end on tag 'e' and on unknown tags.
   task automatic test_tag_walk();
      start_file(1'b1);
      add_field(TAG_A, 16'd2, 2);
      add_field(TAG_A + 8'd1, 16'd0, 0);
      add_field(TAG_A + 8'd2, 16'd1, 1);
      add_field(TAG_D, 16'd3, 3);
      file_q.push_back(TAG_E);
      add_random_bytes(7);
      send_file();
      start_file(1'b1);
      file_q.push_back(TAG_A - 8'd1);
      add_random_bytes(6);
      send_file();
      start_file(1'b1);
      add_field(TAG_D, 16'd0, 0);
      file_q.push_back(TAG_E + 8'd1);
      add_random_bytes(3);
      send_file();
   endtask

   // Short tail after tag 'e', a length past the end, and an overlong file.
   task automatic test_file_edges();
      start_file(1'b1);
      add_field(TAG_A, 16'd2, 2);
      file_q.push_back(TAG_E);
      add_random_bytes(1);
      send_file();
      start_file(1'b1);
      add_field(TAG_A, 16'hFFFF, 0);
      add_random_bytes(4);
      send_file();
      start_file(1'b1);
      add_field(TAG_A + 8'd2, 16'd100, 100);
      send_file();
   endtask

   // Files with no gaps on either channel.
   task automatic test_back_to_back();
      no_idle = 1'b1;
      repeat (6) send_random_file();
      no_idle = 1'b0;
   endtask

   // The receiver stops for a long stretch while files keep arriving.
   task automatic test_receiver_hold_off();
      hold_off_req = 1'b1;
      no_idle      = 1'b1;
      repeat (8) begin
         file_q.delete();
         add_random_bytes($urandom_range(1, 3));
         send_file();
      end
      no_idle = 1'b0;
   endtask

   task automatic test_random_files();
      int start_bytes;
      start_bytes = bytes_accepted;
      while (bytes_accepted - start_bytes < RANDOM_BYTES)
         send_random_file();
   endtask

   // Response ready: a random stall per response, or the long hold-off.
   initial begin : drive_ready
      int stall;
      int hold_cycles;
      rsp_if.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_if.ready <= 1'b0;
            for (hold_cycles = 0; hold_cycles < HOLD_CYCLES; hold_cycles++)
               @(negedge clock);
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         @(negedge clock);
      end
   end

   // Compare each accepted response with the oldest prediction.
   always @(posedge clock) begin : check_response
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_offsets.size() == 0) begin
            $error("unexpected response: payload_offset %0d header_found %0b",
                   rsp_if.payload_offset, rsp_if.header_found);
            fail_count++;
         end else begin
            want = expected_offsets.pop_front();
            if (rsp_if.payload_offset !== want.payload_offset) begin
               $error("payload_offset mismatch: expected %0d, actual %0d",
                      want.payload_offset, rsp_if.payload_offset);
               fail_count++;
            end
            if (rsp_if.header_found !== want.header_found) begin
               $error("header_found mismatch: expected %0b, actual %0b",
                      want.header_found, rsp_if.header_found);
               fail_count++;
            end
         end
      end
   end

   // Test sequence.
   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.byte_value = '0;
      req_if.last_byte  = 1'b0;
      clear_file_state();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_raw_files();
      test_tag_walk();
      test_file_edges();
      test_back_to_back();
      test_receiver_hold_off();
      test_random_files();

      req_if.valid <= 1'b0;
      while (expected_offsets.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
